// ===== hdl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// shared opcodes and item types for the microwire eeprom master
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_EWEN     = 3'd2;
  localparam logic [2:0] OP_EWDS     = 3'd3;
  localparam logic [2:0] OP_SEQ_READ = 3'd4;

  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [5:0]  address;
    logic [15:0] write_data;
    logic [6:0]  word_count;
    logic        data_out_pin;
  } cmd_item_t;

  typedef struct packed {
    logic        chip_select;
    logic        serial_clock;
    logic        data_in_pin;
    logic        busy;
    logic        word_valid;
    logic [15:0] read_word;
    logic        last_word;
    logic        done;
    logic        status;
  } tick_res_t;

endpackage

// ===== hdl/mwm_fifo.sv =====
// ----------------------------------------------------------------------------
// mwm_fifo
// small synchronous queue used between the front, the sequencer and the port
// ----------------------------------------------------------------------------
module mwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/mwm_front.sv =====
// ----------------------------------------------------------------------------
// mwm_front
// accepts tick transactions, classifies the command request and queues it
// ----------------------------------------------------------------------------
module mwm_front #(
  parameter int MAX_WORDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_start_req,
  input  logic [2:0]        in_op,
  input  logic [5:0]        in_address,
  input  logic [15:0]       in_write_data,
  input  logic [6:0]        in_word_count,
  input  logic              in_data_out_pin,
  input  logic              q_pop,
  output logic              q_empty,
  output mwm_pkg::cmd_item_t q_item
);
  import mwm_pkg::*;

  cmd_item_t                 item;
  logic [6:0]                cnt_sat;
  logic [$bits(cmd_item_t)-1:0] q_rdata;

  always_comb begin
    cnt_sat = in_word_count;
    if (in_word_count == 7'd0) begin
      cnt_sat = 7'd1;
    end else if (32'(in_word_count) > MAX_WORDS) begin
      cnt_sat = 7'(MAX_WORDS);
    end
  end

  always_comb begin
    item.start        = in_start_req && (in_op <= OP_SEQ_READ);
    item.op           = in_op;
    item.address      = in_address;
    item.write_data   = in_write_data;
    item.word_count   = (in_op == OP_SEQ_READ) ? cnt_sat : 7'd1;
    item.data_out_pin = in_data_out_pin;
  end

  mwm_fifo #(
    .WIDTH($bits(cmd_item_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_item = cmd_item_t'(q_rdata);

endmodule

// ===== hdl/mwm_seq.sv =====
// ----------------------------------------------------------------------------
// mwm_seq
// bit-level sequencer: frames commands, shifts words in, polls write ready
// ----------------------------------------------------------------------------
module mwm_seq #(
  parameter int ADDR_BITS = 6,
  parameter int WORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [9:0]         busy_poll_limit,
  input  logic               in_empty,
  output logic               in_pop,
  input  mwm_pkg::cmd_item_t in_item,
  input  logic               out_full,
  output logic               out_push,
  output mwm_pkg::tick_res_t out_res
);
  import mwm_pkg::*;

  localparam int SEND_W = 3 + ADDR_BITS + WORD_BITS;
  localparam int CNT_W  = $clog2(SEND_W + 1);
  localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(3 + ADDR_BITS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SEND_W);
  localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEND, PH_RECV, PH_DESEL, PH_POLL, PH_END
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic                 half_r, half_nxt;
  logic [SEND_W-1:0]    send_r, send_nxt;
  logic [WORD_BITS-1:0] recv_r, recv_nxt;
  logic [6:0]           words_r, words_nxt;
  logic [9:0]           poll_r, poll_nxt;
  logic [2:0]           op_r, op_nxt;
  logic                 tmo_r, tmo_nxt;

  logic                 go;
  logic [ADDR_BITS-1:0] addr;
  logic [WORD_BITS-1:0] wdat;
  logic [SEND_W-1:0]    send_init;
  logic [CNT_W-1:0]     cnt_init;
  logic [WORD_BITS-1:0] recv_new;
  logic [9:0]           poll_inc;
  logic [9:0]           lim;
  logic                 pin;
  tick_res_t            res;

  assign go       = !in_empty && !out_full;
  assign in_pop   = go;
  assign out_push = go;
  assign out_res  = res;

  assign addr     = ADDR_BITS'(in_item.address);
  assign wdat     = WORD_BITS'(in_item.write_data);
  assign pin      = in_item.data_out_pin;
  assign recv_new = {recv_r[WORD_BITS-2:0], pin};
  assign poll_inc = poll_r + 10'd1;
  assign lim      = (busy_poll_limit == 10'd0) ? 10'd1 : busy_poll_limit;

  always_comb begin
    cnt_init = HDR_CNT;
    unique case (in_item.op)
      OP_READ:  send_init = {3'b110, addr, {WORD_BITS{1'b0}}};
      OP_WRITE: begin
        send_init = {3'b101, addr, wdat};
        cnt_init  = FULL_CNT;
      end
      OP_EWEN:  send_init = {3'b100, {ADDR_BITS{1'b1}}, {WORD_BITS{1'b0}}};
      OP_EWDS:  send_init = {3'b100, {ADDR_BITS{1'b0}}, {WORD_BITS{1'b0}}};
      default:  send_init = {3'b110, {ADDR_BITS{1'b0}}, {WORD_BITS{1'b0}}};
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    half_nxt    = half_r;
    send_nxt    = send_r;
    recv_nxt    = recv_r;
    words_nxt   = words_r;
    poll_nxt    = poll_r;
    op_nxt      = op_r;
    tmo_nxt     = tmo_r;
    res         = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_item.start) begin
          res.chip_select = 1'b1;
          res.busy        = 1'b1;
          res.data_in_pin = send_init[SEND_W-1];
          phase_nxt       = PH_SEND;
          half_nxt        = 1'b1;
          send_nxt        = send_init;
          bit_cnt_nxt     = cnt_init;
          recv_nxt        = '0;
          tmo_nxt         = 1'b0;
          poll_nxt        = '0;
          words_nxt       = in_item.word_count;
          op_nxt          = in_item.op;
        end
      end
      PH_SEND: begin
        res.chip_select  = 1'b1;
        res.busy         = 1'b1;
        res.serial_clock = half_r;
        res.data_in_pin  = send_r[SEND_W-1];
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt    = 1'b0;
          send_nxt    = send_r << 1;
          bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
          if (bit_cnt_r == CNT_W'(1)) begin
            if (op_r == OP_READ || op_r == OP_SEQ_READ) begin
              phase_nxt   = PH_RECV;
              bit_cnt_nxt = WORD_CNT;
            end else if (op_r == OP_WRITE) begin
              phase_nxt = PH_DESEL;
            end else begin
              phase_nxt = PH_END;
            end
          end
        end
      end
      PH_RECV: begin
        res.chip_select  = 1'b1;
        res.busy         = 1'b1;
        res.serial_clock = half_r;
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt    = 1'b0;
          recv_nxt    = recv_new;
          bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
          if (bit_cnt_r == CNT_W'(1)) begin
            res.word_valid = 1'b1;
            res.read_word  = 16'(recv_new);
            res.last_word  = (words_r <= 7'd1);
            words_nxt      = words_r - 7'd1;
            if (words_r <= 7'd1) begin
              phase_nxt = PH_END;
            end else begin
              bit_cnt_nxt = WORD_CNT;
            end
          end
        end
      end
      PH_DESEL: begin
        res.busy  = 1'b1;
        poll_nxt  = '0;
        phase_nxt = PH_POLL;
      end
      PH_POLL: begin
        res.busy        = 1'b1;
        res.chip_select = 1'b1;
        if (pin) begin
          tmo_nxt   = 1'b0;
          phase_nxt = PH_END;
        end else begin
          poll_nxt = poll_inc;
          if (poll_inc >= lim) begin
            tmo_nxt   = 1'b1;
            phase_nxt = PH_END;
          end
        end
      end
      PH_END: begin
        res.busy   = 1'b1;
        res.done   = 1'b1;
        res.status = tmo_r;
        tmo_nxt    = 1'b0;
        phase_nxt  = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      half_r    <= 1'b0;
      send_r    <= '0;
      recv_r    <= '0;
      words_r   <= '0;
      poll_r    <= '0;
      op_r      <= OP_READ;
      tmo_r     <= 1'b0;
    end else if (go) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      half_r    <= half_nxt;
      send_r    <= send_nxt;
      recv_r    <= recv_nxt;
      words_r   <= words_nxt;
      poll_r    <= poll_nxt;
      op_r      <= op_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

endmodule

// ===== hdl/microwire_eeprom_master_core.sv =====
// path: a tick is registered in the command queue, its result in the result queue
// throughput: one tick transaction per cycle, set by the sequencer taking one queued
//   tick per cycle whenever the result queue has room
// reset: rst_n synchronous active low; clears both queues and the sequencer to idle,
//   and sets busy_poll_limit to 100
// ----------------------------------------------------------------------------
// microwire_eeprom_master_core
// microwire serial eeprom master with queued tick input and result channels
// ----------------------------------------------------------------------------
module microwire_eeprom_master_core #(
  parameter int ADDR_BITS = 6,
  parameter int WORD_BITS = 16,
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_start_req,
  input  logic [2:0]  in_op,
  input  logic [5:0]  in_address,
  input  logic [15:0] in_write_data,
  input  logic [6:0]  in_word_count,
  input  logic        in_data_out_pin,
  output logic        empty,
  input  logic        pop,
  output logic        out_chip_select,
  output logic        out_serial_clock,
  output logic        out_data_in_pin,
  output logic        out_busy_res,
  output logic        out_word_valid,
  output logic [15:0] out_read_word,
  output logic        out_last_word,
  output logic        out_done_res,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mwm_pkg::*;

  localparam logic [9:0] POLL_LIMIT_RST = 10'd100;

  logic [9:0]                   poll_limit_r;
  logic                         cmd_empty, cmd_pop;
  cmd_item_t                    cmd_item;
  logic                         res_full, res_push;
  tick_res_t                    seq_res, res_out;
  logic [$bits(tick_res_t)-1:0] res_rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(poll_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      poll_limit_r <= pwdata[9:0];
    end
  end

  mwm_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_start_req    (in_start_req),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .in_word_count   (in_word_count),
    .in_data_out_pin (in_data_out_pin),
    .q_pop           (cmd_pop),
    .q_empty         (cmd_empty),
    .q_item          (cmd_item)
  );

  mwm_seq #(
    .ADDR_BITS(ADDR_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .busy_poll_limit (poll_limit_r),
    .in_empty        (cmd_empty),
    .in_pop          (cmd_pop),
    .in_item         (cmd_item),
    .out_full        (res_full),
    .out_push        (res_push),
    .out_res         (seq_res)
  );

  mwm_fifo #(
    .WIDTH($bits(tick_res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (seq_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out          = tick_res_t'(res_rdata);
  assign out_chip_select  = res_out.chip_select;
  assign out_serial_clock = res_out.serial_clock;
  assign out_data_in_pin  = res_out.data_in_pin;
  assign out_busy_res     = res_out.busy;
  assign out_word_valid   = res_out.word_valid;
  assign out_read_word    = res_out.read_word;
  assign out_last_word    = res_out.last_word;
  assign out_done_res     = res_out.done;
  assign out_status       = res_out.status;

endmodule
